FILE: rtl/murmur2_byte_stream_hash_assert.svh
// Assertion macros shared by the hash block.
`ifndef MURMUR2_BYTE_STREAM_HASH_ASSERT_SVH
`define MURMUR2_BYTE_STREAM_HASH_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge outside reset
`define MMH_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mmh: implication check failed");

// Next-cycle implication, checked through reset as well
`define MMH_ASSERT_NEXT(name, clk, ante, cons) \
   name: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("mmh: next-cycle check failed");

`else

`define MMH_ASSERT_IMPLY(name, clk, rst, ante, cons)
`define MMH_ASSERT_NEXT(name, clk, ante, cons)

`endif

`endif

FILE: rtl/mmh_pkg.sv
`default_nettype none

package mmh_pkg;

   // Mixing constants
   localparam logic [31:0] MIX_MULT          = 32'h5bd1e995;
   localparam logic [31:0] HASH_SEED         = 32'h0000_0000;
   localparam int          WORD_SHIFT        = 24;
   localparam int          FINAL_SHIFT_A     = 13;
   localparam int          FINAL_SHIFT_B     = 15;

   // Longest message whose length enters the seed unchanged
   localparam logic [31:0] MAX_MESSAGE_BYTES = 32'd65535;

   // Depth of the command queue between front and back
   localparam int          CMD_DEPTH         = 2;

   // One command from the front to the back
   typedef struct packed {
      logic        load_seed;   // first item of a message: reload hash
      logic [15:0] seed_len;    // saturated message length
      logic        has_word;    // a full word is to be mixed in
      logic [31:0] word;        // little-endian word
      logic        is_last;     // finish the message after the word
      logic        has_tail;    // 1 to 3 tail bytes pending
      logic [23:0] tail;        // tail bytes, little-endian
   } mmh_cmd_type;

endpackage

`default_nettype wire

FILE: rtl/mmh_req_if.sv
`default_nettype none

// Byte channel into the hash block
interface mmh_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic [15:0] message_length;
   logic        last_byte;

   modport source (output valid, output data_byte, output message_length,
                   output last_byte, input ready);
   modport sink   (input valid, input data_byte, input message_length,
                   input last_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/mmh_rsp_if.sv
`default_nettype none

// Result channel out of the hash block
interface mmh_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] hash_value;

   modport source (output valid, output hash_value, input ready);
   modport sink   (input valid, input hash_value, output ready);
endinterface

`default_nettype wire

FILE: rtl/murmur2_byte_stream_hash.sv
`default_nettype none
// Channel   Dir   Word                                          Handshake
// req_ch    in    data_byte, message_length, last_byte          valid/ready
// rsp_ch    out   hash_value (one per message)                  valid/ready
//
// The front takes one byte word per cycle while the command queue has room.
// The back pops a command only from idle; each full word then takes two key
// multiplies and one hash multiply, and the end of a message takes tail (if any),
// avalanche and output steps; one shared multiplier sets the pace of these steps.
// Reset is synchronous and empties the queue, the sequencer and the result.
// A stalled result holds in its output register; the front takes bytes until the queue fills.

`include "murmur2_byte_stream_hash_assert.svh"

module murmur2_byte_stream_hash
   import mmh_pkg::*;
#(
   parameter int CMD_QUEUE_DEPTH = CMD_DEPTH
) (
   input  wire logic clock,
   input  wire logic reset,
   mmh_req_if.sink   req_ch,
   mmh_rsp_if.source rsp_ch
);

   logic         q_push;
   logic         q_pop;
   logic         q_full;
   logic         q_empty;
   mmh_cmd_type  push_cmd;
   mmh_cmd_type  pop_cmd;

   // Byte gathering and message framing
   mmh_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .q_full (q_full),
      .q_push (q_push),
      .q_cmd  (push_cmd)
   );

   // Command queue
   mmh_cmd_fifo #(
      .DEPTH (CMD_QUEUE_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .pop_cmd  (pop_cmd),
      .full     (q_full),
      .empty    (q_empty)
   );

   // Mixing and finishing
   mmh_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_cmd   (pop_cmd),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

   // Checks
   `MMH_ASSERT_IMPLY(a_no_push_full, clock, reset, q_push, !q_full)
   `MMH_ASSERT_IMPLY(a_no_pop_empty, clock, reset, q_pop, !q_empty)
   `MMH_ASSERT_NEXT(a_reset_clears, clock, reset, q_empty && !rsp_ch.valid)

endmodule

`default_nettype wire

FILE: rtl/mmh_front.sv
`default_nettype none

module mmh_front
   import mmh_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   mmh_req_if.sink      req_ch,
   input  wire logic    q_full,
   output logic         q_push,
   output mmh_cmd_type  q_cmd
);

   logic        inside_ff, inside_in;
   logic [23:0] gather_ff, gather_in;
   logic [1:0]  pos_ff, pos_in;

   logic        accept;
   logic        start;
   logic        skip;
   logic [15:0] seed_len;
   logic [23:0] gath_cur;
   logic [1:0]  pos_cur;

   assign req_ch.ready = !q_full;
   assign accept       = req_ch.valid && req_ch.ready;

   // Saturate the length and spot the empty message
   always_comb begin
      start = !inside_ff;
      if ({16'b0, req_ch.message_length} > MAX_MESSAGE_BYTES) begin
         seed_len = MAX_MESSAGE_BYTES[15:0];
      end else begin
         seed_len = req_ch.message_length;
      end
      skip     = start && (req_ch.message_length == 16'd0) && req_ch.last_byte;
      gath_cur = start ? 24'd0 : gather_ff;
      pos_cur  = start ? 2'd0 : pos_ff;
   end

   // Gather bytes and build the command
   always_comb begin
      gather_in        = gath_cur;
      pos_in           = pos_cur;
      q_cmd.load_seed  = start;
      q_cmd.seed_len   = seed_len;
      q_cmd.has_word   = 1'b0;
      q_cmd.word       = {req_ch.data_byte, gath_cur};
      q_cmd.is_last    = req_ch.last_byte;
      if (!skip) begin
         unique case (pos_cur)
            2'd0: begin
               gather_in = {16'd0, req_ch.data_byte};
               pos_in    = 2'd1;
            end
            2'd1: begin
               gather_in = {8'd0, req_ch.data_byte, gath_cur[7:0]};
               pos_in    = 2'd2;
            end
            2'd2: begin
               gather_in = {req_ch.data_byte, gath_cur[15:0]};
               pos_in    = 2'd3;
            end
            default: begin
               q_cmd.has_word = 1'b1;
               gather_in      = 24'd0;
               pos_in         = 2'd0;
            end
         endcase
      end
      q_cmd.has_tail = (pos_in != 2'd0);
      q_cmd.tail     = gather_in;
      q_push         = accept && (start || q_cmd.has_word || req_ch.last_byte);
   end

   // Message state
   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff <= 1'b0;
         gather_ff <= '0;
         pos_ff    <= '0;
      end else if (accept) begin
         if (req_ch.last_byte) begin
            inside_ff <= 1'b0;
            gather_ff <= '0;
            pos_ff    <= '0;
         end else begin
            inside_ff <= 1'b1;
            gather_ff <= gather_in;
            pos_ff    <= pos_in;
         end
      end
   end

endmodule

`default_nettype wire

FILE: rtl/mmh_cmd_fifo.sv
`default_nettype none

module mmh_cmd_fifo
   import mmh_pkg::*;
#(
   parameter int DEPTH = CMD_DEPTH
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire mmh_cmd_type  push_cmd,
   input  wire logic         pop,
   output mmh_cmd_type       pop_cmd,
   output logic              full,
   output logic              empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   mmh_cmd_type             slot_ff [DEPTH];
   logic [PTR_W-1:0]        wr_ff, rd_ff;
   logic [CNT_W-1:0]        cnt_ff;

   assign full    = (cnt_ff == FULL_CNT);
   assign empty   = (cnt_ff == '0);
   assign pop_cmd = slot_ff[rd_ff];

   // Pointers and level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == LAST_PTR) ? '0 : wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= (rd_ff == LAST_PTR) ? '0 : rd_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/mmh_back.sv
`default_nettype none

module mmh_back
   import mmh_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         q_empty,
   input  wire mmh_cmd_type  q_cmd,
   output logic              q_pop,
   mmh_rsp_if.source         rsp_ch
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_KMUL1,
      ST_KMUL2,
      ST_HMIX,
      ST_TAIL,
      ST_FMIX,
      ST_EMIT
   } state_type;

   state_type    state_ff, state_in;
   mmh_cmd_type  cmd_ff, cmd_in;
   logic [31:0]  h_ff, h_in;
   logic [31:0]  k_ff, k_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [31:0]  rsp_hash_ff, rsp_hash_in;

   logic [31:0]  mul_a;
   logic [31:0]  mul_p;

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.hash_value = rsp_hash_ff;

   // Shared constant multiplier, one product per cycle
   assign mul_p = mul_a * MIX_MULT;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      h_in         = h_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_hash_in  = rsp_hash_ff;
      q_pop        = 1'b0;
      mul_a        = h_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               cmd_in = q_cmd;
               if (q_cmd.load_seed) begin
                  h_in = HASH_SEED ^ {16'd0, q_cmd.seed_len};
               end
               if (q_cmd.has_word) begin
                  state_in = ST_KMUL1;
               end else if (q_cmd.is_last) begin
                  state_in = q_cmd.has_tail ? ST_TAIL : ST_FMIX;
               end
            end
         end
         ST_KMUL1: begin
            mul_a    = cmd_ff.word;
            k_in     = mul_p;
            state_in = ST_KMUL2;
         end
         ST_KMUL2: begin
            mul_a    = k_ff ^ (k_ff >> WORD_SHIFT);
            k_in     = mul_p;
            state_in = ST_HMIX;
         end
         ST_HMIX: begin
            mul_a = h_ff;
            h_in  = mul_p ^ k_ff;
            if (cmd_ff.is_last) begin
               state_in = cmd_ff.has_tail ? ST_TAIL : ST_FMIX;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_TAIL: begin
            mul_a    = h_ff ^ {8'd0, cmd_ff.tail};
            h_in     = mul_p;
            state_in = ST_FMIX;
         end
         ST_FMIX: begin
            mul_a    = h_ff ^ (h_ff >> FINAL_SHIFT_A);
            h_in     = mul_p;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_hash_in  = h_ff ^ (h_ff >> FINAL_SHIFT_B);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      h_ff        <= h_in;
      k_ff        <= k_in;
      rsp_hash_ff <= rsp_hash_in;
   end

endmodule

`default_nettype wire
